// ===== rtl/casc_pkg.sv =====
// Shared widths, register indexes and codes of the custom alphabet shift codec.
package casc_pkg;

  localparam int SYM_W          = 24;
  localparam int SHIFT_W        = 32;
  localparam int RANGE_W        = 42;
  localparam int CNT_W          = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 42;
  localparam int NUM_RANGE_REGS = 6;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 3'd1;

  // range_a after reset: ' ' .. '~'
  localparam logic [RANGE_W-1:0] RESET_RANGE_A   = 42'd264241184;
  localparam logic [CNT_W-1:0]   RESET_RANGE_CNT = 3'd1;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

endpackage

// ===== rtl/casc_req_if.sv =====
// Request channel: command, symbol and shift with valid/ready.
interface casc_req_if import casc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [SYM_W-1:0]          symbol_in;
  logic signed [SHIFT_W-1:0] shift;

  modport source (output valid, cmd, symbol_in, shift, input ready);
  modport sink   (input valid, cmd, symbol_in, shift, output ready);
endinterface

// ===== rtl/casc_rsp_if.sv =====
// Response channel: result symbol and in-set flag with valid/ready.
interface casc_rsp_if import casc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_out;
  logic             in_set;

  modport source (output valid, symbol_out, in_set, input ready);
  modport sink   (input valid, symbol_out, in_set, output ready);
endinterface

// ===== rtl/custom_alphabet_shift_codec_core.sv =====
// Top level: pipelined shift codec over an alphabet built from configured code-point ranges.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    cmd, symbol_in, shift
//   rsp      out  valid / ready    symbol_out, in_set
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// One beat per cycle sustained while rsp keeps up and the tables are not rebuilding. The
// modulo is a restoring remainder pipeline, one dividend bit per stage.
// rst is synchronous; req.ready stays low after reset and after each configuration
// write while length and prefix tables rebuild.
// A one-beat skid behind the output register keeps the pipeline moving for one
// more beat when rsp stalls; then the whole pipeline holds.
module custom_alphabet_shift_codec_core import casc_pkg::*; #(
  parameter int MAX_RANGES = 6,
  parameter int CODE_WIDTH = 21
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  casc_req_if.sink              req,
  casc_rsp_if.source            rsp
);

  localparam int NR   = (MAX_RANGES < NUM_RANGE_REGS) ? MAX_RANGES : NUM_RANGE_REGS;
  localparam int CW   = CODE_WIDTH;
  localparam int LW   = CW + $clog2(NR + 1);
  localparam int AW   = (LW > SYM_W) ? LW : SYM_W;
  localparam int XW   = ((AW > SHIFT_W) ? AW : SHIFT_W) + 2;
  localparam int MW   = XW - 1;
  localparam int EW   = (2 * CW > RANGE_W) ? 2 * CW : RANGE_W;
  localparam int CMPW = (CW > SYM_W) ? CW : SYM_W;
  localparam int TW   = (LW > SYM_W) ? LW : SYM_W;

  // configuration
  logic [CNT_W-1:0]   range_count;
  logic [RANGE_W-1:0] range_reg [NR];
  logic [1:0]         settle;

  // derived tables
  logic [CW-1:0] rstart [NR];
  logic [CW-1:0] rend   [NR];
  logic [CW:0]   rlen   [NR];
  logic [LW-1:0] prefix [NR+1];
  logic [LW-1:0] prefix_next [NR+1];
  logic [LW-1:0] total;

  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= RESET_RANGE_CNT;
      for (int i = 0; i < NR; i++) begin
        range_reg[i] <= (i == 0) ? RESET_RANGE_A : '0;
      end
      settle <= 2'd2;
    end else if (cfg_we) begin
      if (cfg_index == REG_RANGE_COUNT) begin
        range_count <= cfg_data[CNT_W-1:0];
      end
      for (int i = 0; i < NR; i++) begin
        if (cfg_index == REG_RANGE_FIRST + CFG_IDX_W'(i)) begin
          range_reg[i] <= cfg_data[RANGE_W-1:0];
        end
      end
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // length of each range in use; unused or inverted ranges count as empty
  always_ff @(posedge clk) begin
    for (int i = 0; i < NR; i++) begin
      logic [EW-1:0] ext;
      ext       = EW'(range_reg[i]);
      rstart[i] <= ext[CW-1:0];
      rend[i]   <= ext[2*CW-1:CW];
      if (({1'b0, range_count} > (CNT_W+1)'(i)) && (ext[2*CW-1:CW] >= ext[CW-1:0])) begin
        rlen[i] <= {1'b0, ext[2*CW-1:CW]} - {1'b0, ext[CW-1:0]} + (CW+1)'(1);
      end else begin
        rlen[i] <= '0;
      end
    end
  end

  always_comb begin
    prefix_next[0] = '0;
    for (int i = 0; i < NR; i++) begin
      prefix_next[i+1] = prefix_next[i] + LW'(rlen[i]);
    end
  end

  always_ff @(posedge clk) begin
    prefix <= prefix_next;
  end

  assign total = prefix[NR];

  // ---------------- stage 0: capture
  logic                      v0, c0;
  logic [SYM_W-1:0]          sym0;
  logic signed [SHIFT_W-1:0] sh0;

  assign req.ready = en && (settle == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req.valid && req.ready;
    end
    if (en) begin
      c0   <= req.cmd;
      sym0 <= req.symbol_in;
      sh0  <= req.shift;
    end
  end

  // ---------------- stage 1: find first range holding the symbol
  logic                      v1, c1, f1;
  logic [SYM_W-1:0]          sym1;
  logic signed [SHIFT_W-1:0] sh1;
  logic [LW-1:0]             ps1;
  logic [CW-1:0]             st1;
  logic                      hit_f;
  logic [LW-1:0]             hit_ps;
  logic [CW-1:0]             hit_st;

  always_comb begin
    hit_f  = 1'b0;
    hit_ps = '0;
    hit_st = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if ((rlen[i] != '0) && (CMPW'(sym0) >= CMPW'(rstart[i]))
          && (CMPW'(sym0) <= CMPW'(rend[i]))) begin
        hit_f  = 1'b1;
        hit_ps = prefix[i];
        hit_st = rstart[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      c1   <= c0;
      f1   <= hit_f;
      sym1 <= sym0;
      sh1  <= sh0;
      ps1  <= hit_ps;
      st1  <= hit_st;
    end
  end

  // ---------------- stage 2: alphabet position
  logic                      v2, c2, f2;
  logic signed [SHIFT_W-1:0] sh2;
  logic [AW-1:0]             a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      c2  <= c1;
      f2  <= f1;
      sh2 <= sh1;
      a2  <= (c1 == CMD_DECODE) ? AW'(sym1) : AW'(ps1) + AW'(sym1) - AW'(st1);
    end
  end

  // ---------------- stage 3: add shift, split sign and magnitude
  logic              v3, c3, f3, n3;
  logic [MW-1:0]     m3;
  logic signed [XW-1:0] xs;
  logic [XW-1:0]     xmag;

  always_comb begin
    xs   = $signed({{(XW-AW){1'b0}}, a2}) + XW'(sh2);
    xmag = xs[XW-1] ? XW'(-xs) : XW'(xs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      c3 <= c2;
      f3 <= f2;
      n3 <= xs[XW-1];
      m3 <= xmag[MW-1:0];
    end
  end

  // ---------------- remainder pipeline: one magnitude bit per stage
  logic          dv [MW];
  logic          dc [MW];
  logic          df [MW];
  logic          dn [MW];
  logic [MW-1:0] dm [MW];
  logic [LW-1:0] dr [MW];

  for (genvar k = 0; k < MW; k++) begin : g_div
    logic          pv, pc, pf, pn;
    logic [MW-1:0] pm;
    logic [LW-1:0] pr;
    logic [LW:0]   rt;

    if (k == 0) begin : g_first
      assign pv = v3;
      assign pc = c3;
      assign pf = f3;
      assign pn = n3;
      assign pm = m3;
      assign pr = '0;
    end else begin : g_next
      assign pv = dv[k-1];
      assign pc = dc[k-1];
      assign pf = df[k-1];
      assign pn = dn[k-1];
      assign pm = dm[k-1];
      assign pr = dr[k-1];
    end

    assign rt = {pr, pm[MW-1-k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= pv;
      end
      if (en) begin
        dc[k] <= pc;
        df[k] <= pf;
        dn[k] <= pn;
        dm[k] <= pm;
        if (rt >= {1'b0, total}) begin
          dr[k] <= LW'(rt - {1'b0, total});
        end else begin
          dr[k] <= rt[LW-1:0];
        end
      end
    end
  end

  // ---------------- stage 5: fold negative remainder into range
  logic          v5, c5, f5;
  logic [LW-1:0] idx5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= dv[MW-1];
    end
    if (en) begin
      c5   <= dc[MW-1];
      f5   <= df[MW-1];
      idx5 <= (dn[MW-1] && (dr[MW-1] != '0)) ? total - dr[MW-1] : dr[MW-1];
    end
  end

  // ---------------- stage 6: find the range an index falls in
  logic          v6, c6, f6;
  logic [LW-1:0] idx6, ps6;
  logic [CW-1:0] st6;
  logic [LW-1:0] map_ps;
  logic [CW-1:0] map_st;

  always_comb begin
    map_ps = '0;
    map_st = '0;
    for (int i = NR - 1; i >= 0; i--) begin
      if ((rlen[i] != '0) && (idx5 >= prefix[i]) && (idx5 < prefix[i+1])) begin
        map_ps = prefix[i];
        map_st = rstart[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      c6   <= c5;
      f6   <= f5;
      idx6 <= idx5;
      ps6  <= map_ps;
      st6  <= map_st;
    end
  end

  // ---------------- stage 7: form result
  logic             pv7, pi7;
  logic [SYM_W-1:0] pd7;
  logic [TW-1:0]    dec_cp;

  assign dec_cp = TW'(st6) + TW'(idx6 - ps6);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv7 <= 1'b0;
    end else if (en) begin
      pv7 <= v6;
    end
    if (en) begin
      if (c6 == CMD_DECODE) begin
        pi7 <= 1'b1;
        pd7 <= (total == '0) ? '0 : dec_cp[SYM_W-1:0];
      end else begin
        pi7 <= f6;
        pd7 <= f6 ? SYM_W'(idx6) : '0;
      end
    end
  end

  // ---------------- output register and skid
  logic             ov, oi, sv, si;
  logic [SYM_W-1:0] od, sd;
  logic             out_free;

  assign en       = !sv;
  assign out_free = !ov || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (out_free) begin
      if (sv) begin
        ov <= 1'b1;
        od <= sd;
        oi <= si;
        sv <= 1'b0;
      end else begin
        ov <= pv7;
        od <= pd7;
        oi <= pi7;
      end
    end else if (pv7 && !sv) begin
      // output stalled: park this beat
      sv <= 1'b1;
      sd <= pd7;
      si <= pi7;
    end
  end

  assign rsp.valid      = ov;
  assign rsp.symbol_out = od;
  assign rsp.in_set     = oi;

`ifndef SYNTHESIS
  a_cfg_blocks_req: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req.ready)
    else $error("request accepted right after a configuration write");

  a_skid_blocks_req: assert property (@(posedge clk) disable iff (rst)
    sv |-> !req.ready)
    else $error("request accepted while skid is full");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.in_set) |-> (rsp.symbol_out == '0))
    else $error("encode miss with nonzero result");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (sv && out_free) |=> (ov && !sv))
    else $error("skid beat not moved to output");
`endif

endmodule

// ===== tb/custom_alphabet_shift_codec_core_tb.sv =====
// Testbench for the custom alphabet shift codec: random config phases, scoreboard check.
`timescale 1ns / 100ps

module custom_alphabet_shift_codec_core_tb;
  import casc_pkg::*;

  localparam int IDLE_DRAIN = 60;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [SYM_W-1:0] symbol_out;
    logic             in_set;
  } codec_result_t;

  class codec_scoreboard;
    logic [CNT_W-1:0]   range_cnt;
    logic [RANGE_W-1:0] ranges[NUM_RANGE_REGS];
    codec_result_t      expected_q[$];
    int                 errors;
    int                 checked;

    function new();
      range_cnt = RESET_RANGE_CNT;
      foreach (ranges[i]) ranges[i] = '0;
      ranges[0] = RESET_RANGE_A;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_RANGE_COUNT) range_cnt = data[CNT_W-1:0];
      else if (idx <= NUM_RANGE_REGS) ranges[idx - REG_RANGE_FIRST] = data[RANGE_W-1:0];
    endfunction

    function int ranges_used();
      return (range_cnt > NUM_RANGE_REGS) ? NUM_RANGE_REGS : int'(range_cnt);
    endfunction

    function longint range_lo(int i);
      return longint'(ranges[i][20:0]);
    endfunction

    function longint range_hi(int i);
      return longint'(ranges[i][41:21]);
    endfunction

    function longint range_len(int i);
      return (range_hi(i) < range_lo(i)) ? 0 : range_hi(i) - range_lo(i) + 1;
    endfunction

    function longint alphabet_len();
      longint total;
      total = 0;
      for (int i = 0; i < ranges_used(); i++) total += range_len(i);
      return total;
    endfunction

    // true modulo of a shifted position
    function longint shifted_pos(longint a, logic signed [SHIFT_W-1:0] sh, longint len);
      longint m;
      m = longint'(sh) % len;
      if (m < 0) m += len;
      return ((a % len) + m) % len;
    endfunction

    function void note_request(logic cmd, logic [SYM_W-1:0] sym,
                               logic signed [SHIFT_W-1:0] sh);
      codec_result_t r;
      longint total, pos, idx, s;
      r.symbol_out = '0;
      r.in_set = 1'b0;
      total = alphabet_len();
      s = longint'(sym);
      if (cmd == CMD_ENCODE) begin
        pos = 0;
        for (int i = 0; i < ranges_used(); i++) begin
          if (range_len(i) != 0 && s >= range_lo(i) && s <= range_hi(i)) begin
            r.symbol_out = SYM_W'(shifted_pos(pos + s - range_lo(i), sh, total));
            r.in_set = 1'b1;
            break;
          end
          pos += range_len(i);
        end
      end else begin
        r.in_set = 1'b1;
        if (total != 0) begin
          idx = shifted_pos(s, sh, total);
          for (int i = 0; i < ranges_used(); i++) begin
            if (idx < range_len(i)) begin
              r.symbol_out = SYM_W'(range_lo(i) + idx);
              break;
            end
            idx -= range_len(i);
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [SYM_W-1:0] sym_out, logic in_set);
      codec_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: symbol_out=%h in_set=%b", sym_out, in_set);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (sym_out !== e.symbol_out) begin
        $error("symbol_out mismatch: expected %h actual %h", e.symbol_out, sym_out);
        errors++;
      end
      if (in_set !== e.in_set) begin
        $error("in_set mismatch: expected %b actual %b", e.in_set, in_set);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic quiet;
  int   stall_cycles = 0;
  int   phases_run;

  casc_req_if req ();
  casc_rsp_if rsp ();

  custom_alphabet_shift_codec_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  codec_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure in bursts
  initial begin
    rsp.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.symbol_out, rsp.in_set);
  end

  // count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [SYM_W-1:0] sym, logic signed [SHIFT_W-1:0] sh);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.symbol_in <= sym;
    req.shift <= sh;
    do @(posedge clk); while (!req.ready);
    sb.note_request(cmd, sym, sh);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (IDLE_DRAIN) @(posedge clk);
  endtask

  task automatic load_config(logic [CNT_W-1:0] cnt, logic [RANGE_W-1:0] regs[NUM_RANGE_REGS]);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_RANGE_COUNT;
    cfg_data <= CFG_DATA_W'(cnt);
    sb.write_reg(REG_RANGE_COUNT, CFG_DATA_W'(cnt));
    for (int i = 0; i < NUM_RANGE_REGS; i++) begin
      @(negedge clk);
      cfg_index <= REG_RANGE_FIRST + CFG_IDX_W'(i);
      cfg_data <= regs[i];
      sb.write_reg(REG_RANGE_FIRST + CFG_IDX_W'(i), regs[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  function automatic logic [RANGE_W-1:0] make_range(int kind);
    logic [20:0] lo, hi;
    case (kind)
      0: begin
        lo = 21'($urandom);
        hi = lo + 21'($urandom_range(0, 300));
        if (hi < lo) hi = 21'h1FFFFF;
      end
      1: begin
        lo = 21'($urandom_range(1, 21'h1FFFFF));
        hi = lo - 21'($urandom_range(1, 50));
      end
      2: begin
        lo = 21'($urandom);
        hi = 21'($urandom);
      end
      default: return {10'($urandom), 32'($urandom)};
    endcase
    return {hi, lo};
  endfunction

  function automatic logic signed [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom);
      3: return -32'sd1;
      default: return 32'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  task automatic random_requests(int count);
    logic [SYM_W-1:0] sym;
    int n, r;
    for (int k = 0; k < count; k++) begin
      n = sb.ranges_used();
      if ($urandom_range(0, 1) == 0) begin
        r = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && sb.range_len(r) > 0 && $urandom_range(0, 9) < 7)
          sym = SYM_W'(sb.range_lo(r) + longint'($urandom) % sb.range_len(r));
        else if ($urandom_range(0, 1) == 0) sym = SYM_W'($urandom);
        else sym = SYM_W'($urandom_range(0, 255));
        send_request(CMD_ENCODE, sym, pick_shift());
      end else begin
        sym = ($urandom_range(0, 2) == 0) ? SYM_W'($urandom) : SYM_W'($urandom_range(0, 400));
        send_request(CMD_DECODE, sym, pick_shift());
      end
    end
  endtask

  initial begin
    logic [RANGE_W-1:0] regs[NUM_RANGE_REGS];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.cmd = CMD_ENCODE;
    req.symbol_in = '0;
    req.shift = '0;
    quiet = 1'b0;
    phases_run = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset alphabet: printable ASCII
    send_request(CMD_ENCODE, SYM_W'(" "), '0);
    send_request(CMD_ENCODE, SYM_W'("~"), '0);
    send_request(CMD_ENCODE, SYM_W'("~"), 32'sd1);
    send_request(CMD_ENCODE, SYM_W'(8'h1F), '0);
    send_request(CMD_ENCODE, SYM_W'(8'h7F), 32'sd5);
    send_request(CMD_ENCODE, '0, '0);
    send_request(CMD_ENCODE, 24'hFFFFFF, -32'sd1);
    send_request(CMD_ENCODE, SYM_W'("A"), -32'sd1);
    send_request(CMD_ENCODE, SYM_W'("A"), 32'sh7FFFFFFF);
    send_request(CMD_ENCODE, SYM_W'("z"), 32'sh80000000);
    send_request(CMD_DECODE, '0, '0);
    send_request(CMD_DECODE, SYM_W'(94), '0);
    send_request(CMD_DECODE, SYM_W'(95), '0);
    send_request(CMD_DECODE, '0, -32'sd1);
    send_request(CMD_DECODE, 24'hFFFFFF, 32'sh7FFFFFFF);
    send_request(CMD_DECODE, 24'hFFFFFF, 32'sh80000000);
    send_request(CMD_DECODE, SYM_W'(10), -32'sd200);
    random_requests(150);
    drain();

    // six small ranges, one empty
    foreach (regs[i]) regs[i] = make_range(0);
    regs[2] = make_range(1);
    load_config(3'd6, regs);
    send_request(CMD_ENCODE, SYM_W'(regs[2][20:0]), '0);
    random_requests(220);
    drain();

    // empty alphabet
    foreach (regs[i]) regs[i] = make_range($urandom_range(0, 3));
    load_config(3'd0, regs);
    random_requests(60);
    drain();

    // count above six saturates; full code range and top single point
    regs[0] = {21'h1FFFFF, 21'h000000};
    regs[1] = {RANGE_W{1'b1}};
    regs[2] = make_range(1);
    regs[3] = make_range(0);
    regs[4] = make_range(3);
    regs[5] = make_range(2);
    load_config(3'd7, regs);
    send_request(CMD_ENCODE, 24'h1FFFFF, '0);
    send_request(CMD_ENCODE, 24'h200000, '0);
    send_request(CMD_DECODE, 24'hFFFFFF, 32'sh7FFFFFFF);
    random_requests(250);
    drain();

    // three overlapping / arbitrary ranges
    foreach (regs[i]) regs[i] = make_range($urandom_range(0, 3));
    regs[1] = {regs[0][41:21] + 21'd10, regs[0][20:0]};
    load_config(3'd3, regs);
    random_requests(250);
    drain();

    // closing phase at full rate
    foreach (regs[i]) regs[i] = make_range($urandom_range(0, 2) == 0 ? 1 : 0);
    load_config(3'd5, regs);
    quiet <= 1'b1;
    random_requests(300);
    drain();

    $display("covered %0d configurations and %0d result beats", phases_run + 1, sb.checked);
    $display("encode and decode over empty, saturated, overlapping and full-range alphabets");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
